// ----- src/kms_pkg.sv -----
package kms_pkg;

	localparam int unsigned OUT_POS_W = 32;
	localparam int unsigned OUT_MISS_W = 7;
	localparam int unsigned OUT_MISS_MAX = 127;

	typedef enum logic [1:0] {
		CMD_PAT_APPEND = 2'd0,
		CMD_CLEAR      = 2'd1,
		CMD_REF_BASE   = 2'd2,
		CMD_RESTART    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [1:0] base;
	} in_word_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0]  match_start;
		logic [OUT_POS_W-1:0]  match_end;
		logic [OUT_MISS_W-1:0] mismatch_count;
		logic                  reverse_strand;
		logic                  last;
	} out_word_t;

	typedef struct packed {
		logic shift_ref;
		logic shift_pat;
	} cell_ctl_t;

endpackage

// ----- src/kms_stream_if.sv -----
interface kms_stream_if #(
	parameter type word_t = logic
);
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- src/kms_cell.sv -----
module kms_cell (
	input  logic               clk,
	input  kms_pkg::cell_ctl_t ctl,
	input  logic [1:0]         win_in,
	input  logic [1:0]         patf_in,
	input  logic [1:0]         pat_base,
	input  logic               pat_wr,
	input  logic               active,
	output logic [1:0]         win_out,
	output logic [1:0]         patf_out,
	output logic               miss_fwd,
	output logic               miss_rev
);

	logic [1:0] win_q;
	logic [1:0] patf_q;
	logic [1:0] patr_q;

	always_ff @(posedge clk) begin
		if (ctl.shift_ref) begin
			win_q <= win_in;
		end
		if (ctl.shift_pat) begin
			patf_q <= patf_in;
		end
		if (pat_wr) begin
			patr_q <= pat_base;
		end
	end

	// The reverse strand compares against the complement, which is 3 minus the code.
	assign miss_fwd = active && (win_q != patf_q);
	assign miss_rev = active && (win_q != ~patr_q);
	assign win_out  = win_q;
	assign patf_out = patf_q;

endmodule

// ----- src/kms_popcount.sv -----
module kms_popcount #(
	parameter int unsigned N = 64,
	parameter int unsigned W = 7
) (
	input  logic         clk,
	input  logic [N-1:0] bits,
	output logic [W-1:0] count
);

	localparam int unsigned LVLS = (N < 2) ? 1 : $clog2(N);
	localparam int unsigned P = 1 << LVLS;

	logic [W-1:0] leaf [P];
	logic [W-1:0] node_q [1:P-1];

	for (genvar k = 0; k < P; k++) begin : g_leaf
		if (k < N) begin : g_real
			assign leaf[k] = W'(bits[k]);
		end else begin : g_pad
			assign leaf[k] = '0;
		end
	end

	for (genvar k = 1; k < P; k++) begin : g_node
		if (2 * k >= P) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[k] <= leaf[2*k-P] + leaf[2*k+1-P];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[k] <= node_q[2*k] + node_q[2*k+1];
			end
		end
	end

	assign count = node_q[1];

endmodule

// ----- src/k_mismatch_sliding_search.sv -----
// A reference base runs through a row of MAX_PATTERN_LEN compare cells and
// then through a registered adder tree of max(1, clog2(MAX_PATTERN_LEN))
// levels for each strand; the block waits in S_COUNT while the tree sums,
// decides in S_DECIDE and hands out its hits in S_EMIT while the result
// side is ready. Pattern bases, clears and restarts are handled directly
// in S_IDLE. The next word is taken once the last hit of the current one
// has been delivered, or after S_DECIDE when there is no hit.
module k_mismatch_sliding_search #(
	parameter int unsigned MAX_PATTERN_LEN = 64,
	parameter int unsigned POSITION_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	kms_stream_if.sink   item,
	kms_stream_if.source result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned N = MAX_PATTERN_LEN;
	localparam int unsigned LEN_W = $clog2(N + 1);
	localparam int unsigned LVLS = (N < 2) ? 1 : $clog2(N);
	localparam int unsigned CNT_W = (LVLS > 1) ? $clog2(LVLS) : 1;
	localparam int unsigned CMP_W = (LEN_W > kms_pkg::OUT_MISS_W) ? LEN_W
		: kms_pkg::OUT_MISS_W;
	localparam int unsigned EXT_W = (POSITION_BITS > kms_pkg::OUT_POS_W) ? POSITION_BITS
		: kms_pkg::OUT_POS_W;
	localparam logic REG_MAX_MISMATCH = 1'b0;
	localparam logic REG_STRAND_MODE  = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_COUNT  = 4'b0010,
		S_DECIDE = 4'b0100,
		S_EMIT   = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [LEN_W-1:0]             len_q;
	logic [LEN_W-1:0]             fill_q;
	logic [POSITION_BITS-1:0]     ref_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [kms_pkg::OUT_MISS_W-1:0] max_q;
	logic                         strand_q;
	logic                         out_valid_q;
	kms_pkg::out_word_t           out_q;

	logic                         acc;
	logic                         append_ok;
	kms_pkg::cell_ctl_t           ctl;
	logic [1:0]                   win_chain [N];
	logic [1:0]                   patf_chain [N];
	logic [N-1:0]                 miss_fwd;
	logic [N-1:0]                 miss_rev;
	logic [LEN_W-1:0]             fcnt;
	logic [LEN_W-1:0]             rcnt;
	logic                         hit;
	logic                         fwd_ok;
	logic                         rev_ok;
	logic [kms_pkg::OUT_MISS_W-1:0] fcnt_sat;
	logic [kms_pkg::OUT_MISS_W-1:0] rcnt_sat;
	logic [POSITION_BITS-1:0]     start_pos;
	logic [EXT_W-1:0]             start_ext;
	logic [EXT_W-1:0]             end_ext;

	assign item.ready = (state_q == S_IDLE);
	assign acc = item.valid && item.ready;
	assign append_ok = (len_q != LEN_W'(N));

	assign ctl.shift_ref = acc && (item.data.cmd == kms_pkg::CMD_REF_BASE);
	assign ctl.shift_pat = acc && (item.data.cmd == kms_pkg::CMD_PAT_APPEND) && append_ok;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [1:0] win_in;
		logic [1:0] patf_in;

		if (i == 0) begin : g_head
			assign win_in  = item.data.base;
			assign patf_in = item.data.base;
		end else begin : g_body
			assign win_in  = win_chain[i-1];
			assign patf_in = patf_chain[i-1];
		end

		kms_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.win_in   (win_in),
			.patf_in  (patf_in),
			.pat_base (item.data.base),
			.pat_wr   (ctl.shift_pat && (len_q == LEN_W'(i))),
			.active   (len_q > LEN_W'(i)),
			.win_out  (win_chain[i]),
			.patf_out (patf_chain[i]),
			.miss_fwd (miss_fwd[i]),
			.miss_rev (miss_rev[i])
		);
	end

	kms_popcount #(.N(N), .W(LEN_W)) u_pop_fwd (
		.clk   (clk),
		.bits  (miss_fwd),
		.count (fcnt)
	);

	kms_popcount #(.N(N), .W(LEN_W)) u_pop_rev (
		.clk   (clk),
		.bits  (miss_rev),
		.count (rcnt)
	);

	always_comb begin
		hit = (len_q != '0) && (fill_q >= len_q);
		fwd_ok = hit && (CMP_W'(fcnt) <= CMP_W'(max_q));
		rev_ok = hit && strand_q && (CMP_W'(rcnt) <= CMP_W'(max_q));
		fcnt_sat = (CMP_W'(fcnt) > CMP_W'(kms_pkg::OUT_MISS_MAX)) ? '1
			: kms_pkg::OUT_MISS_W'(fcnt);
		rcnt_sat = (CMP_W'(rcnt) > CMP_W'(kms_pkg::OUT_MISS_MAX)) ? '1
			: kms_pkg::OUT_MISS_W'(rcnt);
		start_pos = ref_q - POSITION_BITS'(len_q);
		start_ext = EXT_W'(start_pos);
		end_ext = EXT_W'(ref_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= '0;
			fill_q      <= '0;
			ref_q       <= '0;
			cnt_q       <= '0;
			max_q       <= '0;
			strand_q    <= 1'b1;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (psel && penable && pwrite) begin
				case (paddr[2])
					REG_MAX_MISMATCH: max_q <= pwdata[kms_pkg::OUT_MISS_W-1:0];
					REG_STRAND_MODE:  strand_q <= pwdata[0];
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (item.data.cmd)
							kms_pkg::CMD_PAT_APPEND: begin
								if (append_ok) begin
									len_q <= len_q + LEN_W'(1);
								end
							end
							kms_pkg::CMD_CLEAR: begin
								len_q  <= '0;
								fill_q <= '0;
								ref_q  <= '0;
							end
							kms_pkg::CMD_REF_BASE: begin
								if (fill_q != LEN_W'(N)) begin
									fill_q <= fill_q + LEN_W'(1);
								end
								ref_q   <= ref_q + POSITION_BITS'(1);
								cnt_q   <= CNT_W'(LVLS - 1);
								state_q <= S_COUNT;
							end
							kms_pkg::CMD_RESTART: begin
								fill_q <= '0;
								ref_q  <= '0;
							end
							default: ;
						endcase
					end
				end
				S_COUNT: begin
					if (cnt_q == '0) begin
						state_q <= S_DECIDE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_DECIDE: begin
					out_q.match_start <= start_ext[kms_pkg::OUT_POS_W-1:0];
					out_q.match_end   <= end_ext[kms_pkg::OUT_POS_W-1:0];
					if (fwd_ok) begin
						out_q.mismatch_count <= fcnt_sat;
						out_q.reverse_strand <= 1'b0;
						out_q.last           <= !rev_ok;
						out_valid_q          <= 1'b1;
						state_q              <= S_EMIT;
					end else if (rev_ok) begin
						out_q.mismatch_count <= rcnt_sat;
						out_q.reverse_strand <= 1'b1;
						out_q.last           <= 1'b1;
						out_valid_q          <= 1'b1;
						state_q              <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (result.ready) begin
						if (out_q.last) begin
							out_valid_q <= 1'b0;
							state_q     <= S_IDLE;
						end else begin
							out_q.mismatch_count <= rcnt_sat;
							out_q.reverse_strand <= 1'b1;
							out_q.last           <= 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			REG_MAX_MISMATCH: prdata = 32'(max_q);
			REG_STRAND_MODE:  prdata = 32'(strand_q);
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;

endmodule
